[rtl/padded_circular_autocorrelation_unit_assert.svh]
// assertion macros for the padded circular autocorrelation unit
// expects clk and arst_n in scope of the module that uses them
`ifndef PADDED_CIRCULAR_AUTOCORRELATION_UNIT_ASSERT_SVH
`define PADDED_CIRCULAR_AUTOCORRELATION_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PCA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pca_pkg.sv]
// shared types and constants of the padded circular autocorrelation unit
// no dependencies; used by pca_cell, pca_seq, pca_checker and the top level
`timescale 1ns / 1ps

package pca_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int VALUE_W  = 38;
	localparam int LAG_W    = 6;

	// sequencer phases
	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_MUL,
		ST_ACC,
		ST_LOAD,
		ST_FOLD,
		ST_EMIT
	} seq_state_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic shift;  // sample line moves one cell up
		logic mult;   // newest sample multiplies every tap
		logic clear;  // drop tap valid bits at series close
		logic load;   // copy accumulators into the fold lines
		logic fold;   // fold lines move, cells pick up wrap partner
		logic emit;   // accumulators move one cell down
	} cell_ctrl_t;

endpackage

[rtl/pca_cell.sv]
// one lag cell: sample tap, product stage, lag accumulator and fold registers
// depends on pca_pkg
`timescale 1ns / 1ps

module pca_cell #(
	parameter int IDX = 0,
	parameter int DW  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pca_pkg::cell_ctrl_t                  ctrl,
	input  logic [DW-1:0]                        n,
	input  logic [DW-1:0]                        nfft,
	input  logic [DW-1:0]                        wrap_lo,
	input  logic [DW-1:0]                        step,
	input  logic signed [pca_pkg::SAMPLE_W-1:0]  cur,
	input  logic signed [pca_pkg::SAMPLE_W-1:0]  tap_in,
	input  logic                                 tap_vld_in,
	input  logic signed [pca_pkg::VALUE_W-1:0]   acc_in,
	input  logic signed [pca_pkg::VALUE_W-1:0]   up_in,
	input  logic signed [pca_pkg::VALUE_W-1:0]   dn_in,
	output logic signed [pca_pkg::SAMPLE_W-1:0]  tap,
	output logic                                 tap_vld,
	output logic signed [pca_pkg::VALUE_W-1:0]   acc,
	output logic signed [pca_pkg::VALUE_W-1:0]   up,
	output logic signed [pca_pkg::VALUE_W-1:0]   dn
);

	localparam logic [DW-1:0] IDX_D = DW'(IDX);
	localparam logic [DW-1:0] TWO_I = DW'(2 * IDX);

	logic signed [pca_pkg::SAMPLE_W-1:0] tap_q;
	logic                                vld_q;
	logic signed [pca_pkg::PROD_W-1:0]   prod_s2;
	logic                                en_s2;
	logic signed [pca_pkg::VALUE_W-1:0]  acc_q;
	logic signed [pca_pkg::VALUE_W-1:0]  up_q;
	logic signed [pca_pkg::VALUE_W-1:0]  dn_q;
	logic signed [pca_pkg::VALUE_W-1:0]  partner;
	logic                                wrap;
	logic                                hit;

	// sample line, one tap per lag
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			tap_q <= tap_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= tap_vld_in;
		end
	end

	// newest sample times this lag's tap
	always_ff @(posedge clk) begin
		prod_s2 <= cur * tap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2 <= 1'b0;
		end else begin
			en_s2 <= ctrl.mult & vld_q;
		end
	end

	// wrap partner sits at lag nfft-IDX, reached through the up or down line
	always_comb begin
		wrap = (IDX_D > wrap_lo) && (IDX_D < n);
		if (TWO_I >= nfft) begin
			partner = up_q;
			hit     = (TWO_I - nfft) == step;
		end else begin
			partner = dn_q;
			hit     = (nfft - TWO_I) == step;
		end
	end

	// lag accumulator: sums products, adds wrap partner, then shifts out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.emit) begin
			acc_q <= acc_in;
		end else if (ctrl.fold && wrap && hit) begin
			acc_q <= acc_q + partner;
		end else if (en_s2) begin
			acc_q <= acc_q + pca_pkg::VALUE_W'(prod_s2);
		end
	end

	// fold lines, copies of the linear sums moving in opposite directions
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			up_q <= acc_q;
			dn_q <= acc_q;
		end else if (ctrl.fold) begin
			up_q <= up_in;
			dn_q <= dn_in;
		end
	end

	assign tap     = tap_q;
	assign tap_vld = vld_q;
	assign acc     = acc_q;
	assign up      = up_q;
	assign dn      = dn_q;

endmodule

[rtl/pca_seq.sv]
// sequencer: sample count, phase control, fold step and result handshake
// depends on pca_pkg
`timescale 1ns / 1ps

module pca_seq #(
	parameter int MAX_SAMPLES = 64,
	parameter int DW          = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	input  logic                         last,
	output logic                         sample_ready,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [pca_pkg::LAG_W-1:0]    lag_index,
	output logic                         final_lag,
	output pca_pkg::cell_ctrl_t          ctrl,
	output logic [DW-1:0]                n,
	output logic [DW-1:0]                nfft,
	output logic [DW-1:0]                wrap_lo,
	output logic [DW-1:0]                step
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	pca_pkg::seq_state_t state_q;
	pca_pkg::seq_state_t state_d;

	logic [CNT_W-1:0] count_q;
	logic [DW-1:0]    n_q;
	logic [DW-1:0]    step_q;
	logic             mult_s1;
	logic             stored;
	logic             take;
	logic             last_step;

	assign stored    = count_q != CNT_W'(MAX_SAMPLES);
	assign take      = sample_valid && sample_ready;
	assign last_step = step_q == (n_q - DW'(1));

	// padded length and the bound above which a lag picks up a wrapped term
	assign wrap_lo = (n_q >> 1) + DW'(1);
	assign nfft    = n_q + wrap_lo;
	assign n       = n_q;
	assign step    = step_q;

	assign final_lag = last_step;
	assign lag_index = pca_pkg::LAG_W'(step_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pca_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		result_valid = 1'b0;
		ctrl         = '0;
		ctrl.mult    = mult_s1;
		case (state_q)
			pca_pkg::ST_COLLECT: begin
				sample_ready = 1'b1;
				ctrl.shift   = sample_valid && stored;
				if (sample_valid && last) begin
					state_d = pca_pkg::ST_MUL;
				end
			end
			pca_pkg::ST_MUL: begin
				state_d = pca_pkg::ST_ACC;
			end
			pca_pkg::ST_ACC: begin
				state_d = pca_pkg::ST_LOAD;
			end
			pca_pkg::ST_LOAD: begin
				ctrl.load  = 1'b1;
				ctrl.clear = 1'b1;
				state_d    = pca_pkg::ST_FOLD;
			end
			pca_pkg::ST_FOLD: begin
				ctrl.fold = 1'b1;
				if (last_step) begin
					state_d = pca_pkg::ST_EMIT;
				end
			end
			pca_pkg::ST_EMIT: begin
				result_valid = 1'b1;
				ctrl.emit    = result_ready;
				if (result_ready && last_step) begin
					state_d = pca_pkg::ST_COLLECT;
				end
			end
			default: begin
				state_d = pca_pkg::ST_COLLECT;
			end
		endcase
	end

	// sample count and series length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
			mult_s1 <= 1'b0;
		end else begin
			mult_s1 <= take && stored;
			if (take) begin
				if (last) begin
					count_q <= '0;
					n_q     <= DW'(count_q) + DW'(stored);
				end else if (stored) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// fold step, then lag number while results go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			case (state_q)
				pca_pkg::ST_LOAD: begin
					step_q <= '0;
				end
				pca_pkg::ST_FOLD: begin
					step_q <= last_step ? '0 : step_q + DW'(1);
				end
				pca_pkg::ST_EMIT: begin
					if (result_ready) begin
						step_q <= step_q + DW'(1);
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

endmodule

[rtl/padded_circular_autocorrelation_unit.sv]
// channel   | handshake                   | payload
// ----------+-----------------------------+----------------------------------
// samples   | sample_valid / sample_ready | sample, last
// results   | result_valid / result_ready | lag_value, lag_index, final_lag
//
// samples are taken one per cycle; each lands in a row of lag cells, is
// multiplied against every tap in the next cycle and summed the cycle after
// after the sample marked last: pipeline states ST_MUL and ST_ACC, a load
// and the fold pass, then n results, one per cycle while result_ready is high
// the fold pass walks the wrapped partner sums along the cell row, one cell
// a cycle; no new sample is taken from series close until the final result
// reset clears control state and accumulators at once; no clearing pass
//
// top level; depends on pca_pkg, pca_seq and pca_cell
`timescale 1ns / 1ps

module padded_circular_autocorrelation_unit #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic signed [pca_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [pca_pkg::VALUE_W-1:0]  lag_value,
	output logic [pca_pkg::LAG_W-1:0]           lag_index,
	output logic                                final_lag
);

	localparam int DW = $clog2(2 * MAX_SAMPLES + 1);

	pca_pkg::cell_ctrl_t ctrl;
	logic [DW-1:0]       n;
	logic [DW-1:0]       nfft;
	logic [DW-1:0]       wrap_lo;
	logic [DW-1:0]       step;

	logic signed [pca_pkg::SAMPLE_W-1:0] tap    [MAX_SAMPLES];
	logic                                vld    [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  acc    [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  up     [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  dn     [MAX_SAMPLES];
	logic signed [pca_pkg::SAMPLE_W-1:0] tap_lo [MAX_SAMPLES];
	logic                                vld_lo [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  up_lo  [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  acc_hi [MAX_SAMPLES];
	logic signed [pca_pkg::VALUE_W-1:0]  dn_hi  [MAX_SAMPLES];

	// phase control and result handshake
	pca_seq #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.DW          (DW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.last         (last),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.lag_index    (lag_index),
		.final_lag    (final_lag),
		.ctrl         (ctrl),
		.n            (n),
		.nfft         (nfft),
		.wrap_lo      (wrap_lo),
		.step         (step)
	);

	// row of lag cells, neighbours wired at both ends
	for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
		if (g == 0) begin : g_low
			assign tap_lo[g] = sample;
			assign vld_lo[g] = 1'b1;
			assign up_lo[g]  = '0;
		end else begin : g_mid_low
			assign tap_lo[g] = tap[g-1];
			assign vld_lo[g] = vld[g-1];
			assign up_lo[g]  = up[g-1];
		end

		if (g == MAX_SAMPLES - 1) begin : g_high
			assign acc_hi[g] = '0;
			assign dn_hi[g]  = '0;
		end else begin : g_mid_high
			assign acc_hi[g] = acc[g+1];
			assign dn_hi[g]  = dn[g+1];
		end

		pca_cell #(
			.IDX (g),
			.DW  (DW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.n          (n),
			.nfft       (nfft),
			.wrap_lo    (wrap_lo),
			.step       (step),
			.cur        (tap[0]),
			.tap_in     (tap_lo[g]),
			.tap_vld_in (vld_lo[g]),
			.acc_in     (acc_hi[g]),
			.up_in      (up_lo[g]),
			.dn_in      (dn_hi[g]),
			.tap        (tap[g]),
			.tap_vld    (vld[g]),
			.acc        (acc[g]),
			.up         (up[g]),
			.dn         (dn[g])
		);
	end

	// lag 0 cell faces the result port
	assign lag_value = acc[0];

endmodule

[rtl/pca_checker.sv]
// port-level checks of the padded circular autocorrelation unit, bound to the top
// depends on pca_pkg and padded_circular_autocorrelation_unit_assert.svh
`timescale 1ns / 1ps
`include "padded_circular_autocorrelation_unit_assert.svh"

module pca_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                sample_valid,
	input logic                                sample_ready,
	input logic                                last,
	input logic                                result_valid,
	input logic                                result_ready,
	input logic [pca_pkg::LAG_W-1:0]           lag_index,
	input logic                                final_lag
);

	logic                      s_take;
	logic                      r_take;
	logic [pca_pkg::LAG_W-1:0] next_lag;

	// transactions on each channel and the lag expected after this one
	assign s_take   = sample_valid && sample_ready;
	assign r_take   = result_valid && result_ready;
	assign next_lag = lag_index + pca_pkg::LAG_W'(1);

	// a pending result transaction stays offered
	`PCA_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped")

	// samples and results never overlap
	`PCA_ASSERT_SAME(a_no_overlap, result_valid, !sample_ready, "sample taken during results")

	// closing sample is followed at once by closed intake and no result offer
	`PCA_ASSERT_NEXT(a_close_stops, s_take && last, !sample_ready && !result_valid, "intake open")

	// lags count up by one within a run
	`PCA_ASSERT_NEXT(a_lag_step, r_take && !final_lag, lag_index == $past(next_lag), "lag skipped")

	// after the final lag the unit takes samples again
	`PCA_ASSERT_NEXT(a_run_end, r_take && final_lag, !result_valid && sample_ready, "no intake")

endmodule

bind padded_circular_autocorrelation_unit pca_checker u_pca_checker (.*);
